### hw/rtl/vnsl_pkg.sv
// Shared types, constants and helpers for the nearest-seed labeler.
`timescale 1ns / 1ps

package vnsl_pkg;

    localparam int DEF_MAX_SEEDS  = 64;
    localparam int DEF_COORD_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_AXES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_Z      = 3'd5;

    localparam logic [16:0] DOMAIN_RESET = 17'h10000;

    // request commands
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // read latency from issue to the compare stage: memory plus distance pipeline
    localparam int DRAIN_CYCLES = 5;

    typedef struct packed {
        logic               command;
        logic [5:0]         seed_index;
        logic [15:0]        seed_x;
        logic [15:0]        seed_y;
        logic [15:0]        seed_z;
        logic signed [31:0] seed_value;
        logic [14:0]        cell_i;
        logic [14:0]        cell_j;
        logic [14:0]        cell_k;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [5:0]         grain_index;
        logic signed [31:0] cell_value;
        logic [5:0]         channel;
        logic [33:0]        distance_sq;
    } rsp_t;

    // width of one axis offset magnitude for a given stored coordinate width
    function automatic int coord_mag_w(input int coord_bits);
        int mw;
        mw = (coord_bits > 17) ? coord_bits : 17;
        return mw + 1;
    endfunction

    // width of the sum of three squared offsets
    function automatic int dist_w(input int coord_bits);
        int ow;
        ow = coord_mag_w(coord_bits);
        return 2 * ow + 2;
    endfunction

endpackage

### hw/rtl/vnsl_seed_mem.sv
// Seed table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module vnsl_seed_mem #(
    parameter int DEPTH = vnsl_pkg::DEF_MAX_SEEDS,
    parameter int AW    = 6,
    parameter int WIDTH = 3 * vnsl_pkg::DEF_COORD_BITS + 32
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/vnsl_axis_off.sv
// One axis of the distance pipeline: signed offsets, then minimum-image magnitude.
`timescale 1ns / 1ps

module vnsl_axis_off #(
    parameter int COORD_BITS = vnsl_pkg::DEF_COORD_BITS
) (
    input  logic                                            clk,
    input  logic [15:0]                                     centre,
    input  logic [COORD_BITS-1:0]                           seed,
    input  logic                                            wrap,
    input  logic [16:0]                                     len,
    output logic [vnsl_pkg::coord_mag_w(COORD_BITS)-1:0]    offset
);

    localparam int OW = vnsl_pkg::coord_mag_w(COORD_BITS);
    localparam int SW = OW + 1;

    logic signed [SW-1:0] d_next;
    logic signed [SW-1:0] dp_next;
    logic signed [SW-1:0] dm_next;
    logic signed [SW-1:0] d_reg;
    logic signed [SW-1:0] dp_reg;
    logic signed [SW-1:0] dm_reg;
    logic [OW-1:0]        mag_d;
    logic [OW-1:0]        mag_p;
    logic [OW-1:0]        mag_m;
    logic [OW-1:0]        off_next;
    logic [OW-1:0]        off_reg;

    function automatic logic [OW-1:0] mag(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] a;
        a = v[SW-1] ? -v : v;
        return a[OW-1:0];
    endfunction

    // stage 1: centre minus seed, and that offset shifted by one domain length
    always_comb
    begin
        d_next  = $signed(SW'(centre)) - $signed(SW'(seed));
        dp_next = d_next + $signed(SW'(len));
        dm_next = d_next - $signed(SW'(len));
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        dp_reg <= dp_next;
        dm_reg <= dm_next;
    end

    // stage 2: smallest magnitude, plain offset first so it wins ties
    always_comb
    begin
        mag_d    = mag(d_reg);
        mag_p    = mag(dp_reg);
        mag_m    = mag(dm_reg);
        off_next = mag_d;
        if (wrap)
        begin
            if (mag_p < off_next)
            begin
                off_next = mag_p;
            end
            if (mag_m < off_next)
            begin
                off_next = mag_m;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
    end

    assign offset = off_reg;

endmodule

### hw/rtl/vnsl_dist_unit.sv
// Shared distance pipeline: three axis offsets, squares, and their sum.
`timescale 1ns / 1ps

module vnsl_dist_unit #(
    parameter int COORD_BITS = vnsl_pkg::DEF_COORD_BITS,
    parameter int AW         = 6
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic [AW-1:0]                               in_idx,
    input  logic signed [31:0]                          in_val,
    input  logic [COORD_BITS-1:0]                       seed_x,
    input  logic [COORD_BITS-1:0]                       seed_y,
    input  logic [COORD_BITS-1:0]                       seed_z,
    input  logic [15:0]                                 cx,
    input  logic [15:0]                                 cy,
    input  logic [15:0]                                 cz,
    input  logic [2:0]                                  wrap,
    input  logic [16:0]                                 len_x,
    input  logic [16:0]                                 len_y,
    input  logic [16:0]                                 len_z,
    output logic                                        out_valid,
    output logic [AW-1:0]                               out_idx,
    output logic signed [31:0]                          out_val,
    output logic [vnsl_pkg::dist_w(COORD_BITS)-1:0]     out_dist
);

    localparam int OW    = vnsl_pkg::coord_mag_w(COORD_BITS);
    localparam int SQW   = vnsl_pkg::dist_w(COORD_BITS);
    localparam int DEPTH = 4;

    logic [OW-1:0]      off_x;
    logic [OW-1:0]      off_y;
    logic [OW-1:0]      off_z;
    logic [2*OW-1:0]    sq_x_reg;
    logic [2*OW-1:0]    sq_y_reg;
    logic [2*OW-1:0]    sq_z_reg;
    logic [SQW-1:0]     sum_reg;

    logic               tag_v_reg   [DEPTH];
    logic [AW-1:0]      tag_idx_reg [DEPTH];
    logic signed [31:0] tag_val_reg [DEPTH];

    vnsl_axis_off #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .clk    (clk),
        .centre (cx),
        .seed   (seed_x),
        .wrap   (wrap[0]),
        .len    (len_x),
        .offset (off_x)
    );

    vnsl_axis_off #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .clk    (clk),
        .centre (cy),
        .seed   (seed_y),
        .wrap   (wrap[1]),
        .len    (len_y),
        .offset (off_y)
    );

    vnsl_axis_off #(.COORD_BITS(COORD_BITS)) u_axis_z (
        .clk    (clk),
        .centre (cz),
        .seed   (seed_z),
        .wrap   (wrap[2]),
        .len    (len_z),
        .offset (off_z)
    );

    // stage 3: squares
    always_ff @(posedge clk)
    begin
        sq_x_reg <= off_x * off_x;
        sq_y_reg <= off_y * off_y;
        sq_z_reg <= off_z * off_z;
    end

    // stage 4: sum
    always_ff @(posedge clk)
    begin
        sum_reg <= SQW'(sq_x_reg) + SQW'(sq_y_reg) + SQW'(sq_z_reg);
    end

    // carry the seed tag alongside the four data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                tag_v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            tag_v_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
            begin
                tag_v_reg[s] <= tag_v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_idx_reg[0] <= in_idx;
        tag_val_reg[0] <= in_val;
        for (int s = 1; s < DEPTH; s++)
        begin
            tag_idx_reg[s] <= tag_idx_reg[s-1];
            tag_val_reg[s] <= tag_val_reg[s-1];
        end
    end

    assign out_valid = tag_v_reg[DEPTH-1];
    assign out_idx   = tag_idx_reg[DEPTH-1];
    assign out_val   = tag_val_reg[DEPTH-1];
    assign out_dist  = sum_reg;

endmodule

### hw/rtl/voronoi_nearest_seed_labeler.sv
// Top level: seed table, scan sequencer, nearest-seed tracker and result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  vnsl_pkg::req_t  (load seed or classify cell)
// rsp       out        rsp_valid/rsp_stall  vnsl_pkg::rsp_t  (one per classify request)
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// A load request gives no result. A classify request searches count seeds, count
// being grain_count saturated to MAX_SEEDS: IDLE accepts it, the scan issues one
// seed read per cycle into the shared distance pipeline, DRAIN waits out the read
// and pipeline latency, and DONE hands off the result.
// req_stall is high from accept until hand-off; the hand-off waits while a held
// result is stalled. Reset clears configuration and control, not the seed table.

module voronoi_nearest_seed_labeler #(
    parameter int MAX_SEEDS  = vnsl_pkg::DEF_MAX_SEEDS,
    parameter int COORD_BITS = vnsl_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  vnsl_pkg::req_t                     req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output vnsl_pkg::rsp_t                     rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vnsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vnsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNTW   = $clog2(MAX_SEEDS + 1);
    localparam int IXW    = (AW > 6) ? AW : 6;
    localparam int SQW    = vnsl_pkg::dist_w(COORD_BITS);
    localparam int MEMW   = 3 * COORD_BITS + 32;
    localparam int DRW    = $clog2(vnsl_pkg::DRAIN_CYCLES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // configuration registers
    logic [6:0]  grain_count_reg;
    logic        output_mode_reg;
    logic [2:0]  periodic_axes_reg;
    logic [16:0] domain_x_reg;
    logic [16:0] domain_y_reg;
    logic [16:0] domain_z_reg;

    // sequencer
    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [CNTW-1:0] iss_reg;
    logic [CNTW-1:0] iss_next;
    logic [DRW-1:0]  drain_reg;
    logic [DRW-1:0]  drain_next;
    logic [15:0]     cx_reg;
    logic [15:0]     cy_reg;
    logic [15:0]     cz_reg;

    // request decode
    logic            req_fire;
    logic            load_fire;
    logic            cls_fire;
    logic [IXW-1:0]  load_idx_ext;
    logic            load_in_range;
    logic [CNTW-1:0] count_sat;

    // seed table
    logic [MEMW-1:0] wr_word;
    logic [MEMW-1:0] rd_word;
    logic            rd_en;
    logic            rd_valid_reg;
    logic [AW-1:0]   rd_idx_reg;

    // distance pipeline output
    logic               dist_valid;
    logic [AW-1:0]      dist_idx;
    logic signed [31:0] dist_val;
    logic [SQW-1:0]     dist_sq;

    // nearest-seed tracker
    logic               have_reg;
    logic [AW-1:0]      best_idx_reg;
    logic signed [31:0] best_val_reg;
    logic [SQW-1:0]     best_dist_reg;
    logic               take_best;

    // result register
    logic               rsp_valid_reg;
    vnsl_pkg::rsp_t     rsp_reg;
    vnsl_pkg::rsp_t     rsp_next;
    logic               rsp_load;
    logic [IXW-1:0]     best_idx_ext;

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration writes; indexes past the register list are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grain_count_reg   <= '0;
            output_mode_reg   <= 1'b0;
            periodic_axes_reg <= '0;
            domain_x_reg      <= vnsl_pkg::DOMAIN_RESET;
            domain_y_reg      <= vnsl_pkg::DOMAIN_RESET;
            domain_z_reg      <= vnsl_pkg::DOMAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vnsl_pkg::CFG_GRAIN_COUNT:   grain_count_reg   <= cfg_data[6:0];
                vnsl_pkg::CFG_OUTPUT_MODE:   output_mode_reg   <= cfg_data[0];
                vnsl_pkg::CFG_PERIODIC_AXES: periodic_axes_reg <= cfg_data[2:0];
                vnsl_pkg::CFG_DOMAIN_X:      domain_x_reg      <= cfg_data;
                vnsl_pkg::CFG_DOMAIN_Y:      domain_y_reg      <= cfg_data;
                vnsl_pkg::CFG_DOMAIN_Z:      domain_z_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request decode. Loads write the table straight away; a load aimed past
    // the end of the table is dropped.
    // ---------------------------------------------------------------------
    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign load_fire = req_fire && (req_data.command == vnsl_pkg::CMD_LOAD);
    assign cls_fire  = req_fire && (req_data.command == vnsl_pkg::CMD_CLASSIFY);

    assign load_idx_ext  = IXW'(req_data.seed_index);
    assign load_in_range = (32'(req_data.seed_index) < 32'(MAX_SEEDS));

    // saturate the searched count to the table depth
    assign count_sat = (32'(grain_count_reg) > 32'(MAX_SEEDS)) ?
                       CNTW'(MAX_SEEDS) : CNTW'(32'(grain_count_reg));

    assign wr_word = {req_data.seed_value,
                      COORD_BITS'(32'(req_data.seed_z)),
                      COORD_BITS'(32'(req_data.seed_y)),
                      COORD_BITS'(32'(req_data.seed_x))};

    assign rd_en = (state_reg == ST_SCAN) && (iss_reg < cnt_reg);

    vnsl_seed_mem #(
        .DEPTH (MAX_SEEDS),
        .AW    (AW),
        .WIDTH (MEMW)
    ) u_seed_mem (
        .clk     (clk),
        .wr_en   (load_fire && load_in_range),
        .wr_addr (load_idx_ext[AW-1:0]),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (rd_word)
    );

    // ---------------------------------------------------------------------
    // Sequencer: IDLE takes a request, SCAN issues one seed read per cycle,
    // DRAIN waits out the pipeline, DONE hands the winner to the result
    // register once that register is free.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        iss_next   = iss_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cls_fire)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = count_sat;
                    iss_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (iss_reg < cnt_reg)
                begin
                    iss_next = iss_reg + CNTW'(1);
                end
                else
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRW'(vnsl_pkg::DRAIN_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    drain_next = drain_reg + DRW'(1);
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            iss_reg      <= '0;
            drain_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            drain_reg    <= drain_next;
            rd_valid_reg <= rd_en;
        end
    end

    // cell centre in half-cell units: 2*i + 1
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= iss_reg[AW-1:0];
        if (cls_fire)
        begin
            cx_reg <= {req_data.cell_i, 1'b1};
            cy_reg <= {req_data.cell_j, 1'b1};
            cz_reg <= {req_data.cell_k, 1'b1};
        end
    end

    vnsl_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_idx    (rd_idx_reg),
        .in_val    (rd_word[MEMW-1 -: 32]),
        .seed_x    (rd_word[COORD_BITS-1:0]),
        .seed_y    (rd_word[2*COORD_BITS-1 -: COORD_BITS]),
        .seed_z    (rd_word[3*COORD_BITS-1 -: COORD_BITS]),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .cz        (cz_reg),
        .wrap      (periodic_axes_reg),
        .len_x     (domain_x_reg),
        .len_y     (domain_y_reg),
        .len_z     (domain_z_reg),
        .out_valid (dist_valid),
        .out_idx   (dist_idx),
        .out_val   (dist_val),
        .out_dist  (dist_sq)
    );

    // ---------------------------------------------------------------------
    // Nearest-seed tracker. Seeds arrive in index order, so a strict less-than
    // keeps the lowest index on a tie.
    // ---------------------------------------------------------------------
    assign take_best = dist_valid && (!have_reg || (dist_sq < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cls_fire)
        begin
            have_reg <= 1'b0;
        end
        else if (dist_valid)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_idx_reg  <= dist_idx;
            best_val_reg  <= dist_val;
            best_dist_reg <= dist_sq;
        end
    end

    // ---------------------------------------------------------------------
    // Result register: load from DONE when empty or being drained this cycle.
    // With no seed searched every field reads zero.
    // ---------------------------------------------------------------------
    assign rsp_load     = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign best_idx_ext = IXW'(best_idx_reg);

    always_comb
    begin
        rsp_next = '0;
        if (have_reg)
        begin
            rsp_next.found       = 1'b1;
            rsp_next.grain_index = best_idx_ext[5:0];
            rsp_next.cell_value  = best_val_reg;
            rsp_next.channel     = output_mode_reg ? best_idx_ext[5:0] : 6'd0;
            rsp_next.distance_sq = best_dist_reg[33:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // issue pointer never runs past the searched count
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_reg <= cnt_reg))
        else $error("seed issue pointer past searched count");

    // distances only come back while a scan is in flight
    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance result outside a scan");

    // drain long enough: a non-empty scan has seen at least one distance by DONE
    a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (cnt_reg != '0)) |-> have_reg)
        else $error("scan finished before its distances arrived");

    // a result only appears as the sequencer leaves DONE
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside DONE");

endmodule
